>>> design/csc_pkg.sv
`timescale 1ns / 1ps
// Shared types, command and relation codes, register indexes and the month length
// function for the calendar second counter. This file depends on nothing else.
package csc_pkg;

	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	// Command codes carried in the cmd field.
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_FWD  = 2'd1;
	localparam logic [1:0] CMD_BACK = 2'd2;

	// Relation codes returned with every result.
	localparam logic [1:0] REL_BEFORE = 2'd0;
	localparam logic [1:0] REL_EQUAL  = 2'd1;
	localparam logic [1:0] REL_AFTER  = 2'd2;

	// Register indexes; register i sits at byte address 4*i.
	localparam logic [2:0] REG_YEAR   = 3'd0;
	localparam logic [2:0] REG_MONTH  = 3'd1;
	localparam logic [2:0] REG_DAY    = 3'd2;
	localparam logic [2:0] REG_HOUR   = 3'd3;
	localparam logic [2:0] REG_MINUTE = 3'd4;
	localparam logic [2:0] REG_SECOND = 3'd5;

	localparam logic [6:0] YEAR_MAX    = 7'd99;
	localparam logic [6:0] YEAR_WINDOW = 7'd70;
	localparam logic [3:0] MONTH_MAX   = 4'd12;
	localparam logic [4:0] HOUR_MAX    = 5'd23;
	localparam logic [5:0] MINSEC_MAX  = 6'd59;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} time_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] load_year;
		logic [3:0] load_month;
		logic [4:0] load_day;
		logic [4:0] load_hour;
		logic [5:0] load_minute;
		logic [5:0] load_second;
	} in_beat_t;

	typedef struct packed {
		logic [6:0] out_year;
		logic [3:0] out_month;
		logic [4:0] out_day;
		logic [4:0] out_hour;
		logic [5:0] out_minute;
		logic [5:0] out_second;
		logic [1:0] relation;
	} out_beat_t;

	// Days in a month; every year divisible by four is a leap year.
	function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
		logic [4:0] len;
		unique case (m)
			4'd2: begin
				len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

>>> design/csc_step.sv
`timescale 1ns / 1ps
// Next date-time logic: load with saturation, one second forward, one second back, or hold.
// Depends on csc_pkg for the time and beat types and the month length function.
module csc_step import csc_pkg::*; (
	input  in_beat_t beat,
	input  time_t    cur,
	output time_t    nxt
);

	time_t      ld;
	time_t      fw;
	time_t      bk;
	logic [4:0] ld_day_max;

	// Load saturates each field into its range, the day against the loaded month.
	always_comb begin
		ld.year   = (beat.load_year > YEAR_MAX) ? YEAR_MAX : beat.load_year;
		ld.month  = (beat.load_month == 4'd0) ? 4'd1 :
			((beat.load_month > MONTH_MAX) ? MONTH_MAX : beat.load_month);
		ld_day_max = month_length(ld.month, ld.year);
		ld.day    = (beat.load_day == 5'd0) ? 5'd1 :
			((beat.load_day > ld_day_max) ? ld_day_max : beat.load_day);
		ld.hour   = (beat.load_hour > HOUR_MAX) ? HOUR_MAX : beat.load_hour;
		ld.minute = (beat.load_minute > MINSEC_MAX) ? MINSEC_MAX : beat.load_minute;
		ld.second = (beat.load_second > MINSEC_MAX) ? MINSEC_MAX : beat.load_second;
	end

	always_comb begin
		fw = cur;
		if (cur.second < MINSEC_MAX) begin
			fw.second = cur.second + 6'd1;
		end else begin
			fw.second = 6'd0;
			if (cur.minute < MINSEC_MAX) begin
				fw.minute = cur.minute + 6'd1;
			end else begin
				fw.minute = 6'd0;
				if (cur.hour < HOUR_MAX) begin
					fw.hour = cur.hour + 5'd1;
				end else begin
					fw.hour = 5'd0;
					if (cur.day < month_length(cur.month, cur.year)) begin
						fw.day = cur.day + 5'd1;
					end else begin
						fw.day = 5'd1;
						if (cur.month < MONTH_MAX) begin
							fw.month = cur.month + 4'd1;
						end else begin
							fw.month = 4'd1;
							fw.year  = (cur.year >= YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		bk = cur;
		if (cur.second != 6'd0) begin
			bk.second = cur.second - 6'd1;
		end else begin
			bk.second = MINSEC_MAX;
			if (cur.minute != 6'd0) begin
				bk.minute = cur.minute - 6'd1;
			end else begin
				bk.minute = MINSEC_MAX;
				if (cur.hour != 5'd0) begin
					bk.hour = cur.hour - 5'd1;
				end else begin
					bk.hour = HOUR_MAX;
					if (cur.day > 5'd1) begin
						bk.day = cur.day - 5'd1;
					end else begin
						if (cur.month > 4'd1) begin
							bk.month = cur.month - 4'd1;
						end else begin
							bk.month = MONTH_MAX;
							bk.year  = (cur.year == 7'd0) ? YEAR_MAX : cur.year - 7'd1;
						end
						bk.day = month_length(bk.month, bk.year);
					end
				end
			end
		end
	end

	always_comb begin
		unique case (beat.cmd)
			CMD_LOAD: begin
				nxt = ld;
			end
			CMD_FWD: begin
				nxt = fw;
			end
			CMD_BACK: begin
				nxt = bk;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> design/csc_cmp.sv
`timescale 1ns / 1ps
// Windowed compare of a date-time against the reference date-time.
// Depends on csc_pkg for the time type and the relation codes.
module csc_cmp import csc_pkg::*; (
	input  time_t      cur,
	input  time_t      ref_time,
	output logic [1:0] relation
);

	// The fields are packed year first, so one wide compare orders them lexically.
	always_comb begin
		priority if (cur.year < YEAR_WINDOW && ref_time.year > YEAR_WINDOW) begin
			relation = REL_AFTER;
		end else if (cur.year > YEAR_WINDOW && ref_time.year < YEAR_WINDOW) begin
			relation = REL_BEFORE;
		end else if (cur > ref_time) begin
			relation = REL_AFTER;
		end else if (cur < ref_time) begin
			relation = REL_BEFORE;
		end else begin
			relation = REL_EQUAL;
		end
	end

endmodule

>>> design/calendar_second_counter.sv
`timescale 1ns / 1ps
// Top level of the calendar second counter: time register, reference registers, result stage.
// Depends on csc_pkg, csc_step and csc_cmp.
//
//   channel   signals                              beat
//   in        in_valid / in_ready / in_data        one command with load fields
//   out       out_valid / out_ready / out_data     time after the command and relation
//   cfg       psel penable pwrite paddr pwdata     one reference field write or read
//
// The next time and its compare with the reference are computed from the time register
// in one pass and captured in the result register.
// A new command is taken in every cycle while the result register is empty or drains.
// Reset puts the time at year 0, January 1, 00:00:00 and the reference at the same.
// When out_ready is low with a result held, in_ready drops and nothing is lost.
module calendar_second_counter import csc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_beat_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_beat_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	time_t      time_q;
	time_t      ref_q;
	time_t      time_nxt;
	logic [1:0] relation_nxt;
	logic       out_valid_q;
	out_beat_t  out_data_q;
	logic       in_acc;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	// The result register frees up in the same cycle that its beat is taken.
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	// The port never stalls; a write lands on the access cycle.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_AW-1:2];

	csc_step u_step (
		.beat (in_data),
		.cur  (time_q),
		.nxt  (time_nxt)
	);

	// The compare sees the time after the command, as the result reports it.
	csc_cmp u_cmp (
		.cur      (time_nxt),
		.ref_time (ref_q),
		.relation (relation_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
				second: 6'd0};
		end else if (in_acc) begin
			time_q <= time_nxt;
		end
	end

	// Reference registers; writes to addresses past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
				second: 6'd0};
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_YEAR: begin
					ref_q.year <= pwdata[6:0];
				end
				REG_MONTH: begin
					ref_q.month <= pwdata[3:0];
				end
				REG_DAY: begin
					ref_q.day <= pwdata[4:0];
				end
				REG_HOUR: begin
					ref_q.hour <= pwdata[4:0];
				end
				REG_MINUTE: begin
					ref_q.minute <= pwdata[5:0];
				end
				REG_SECOND: begin
					ref_q.second <= pwdata[5:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_YEAR: begin
				prdata = APB_DW'(ref_q.year);
			end
			REG_MONTH: begin
				prdata = APB_DW'(ref_q.month);
			end
			REG_DAY: begin
				prdata = APB_DW'(ref_q.day);
			end
			REG_HOUR: begin
				prdata = APB_DW'(ref_q.hour);
			end
			REG_MINUTE: begin
				prdata = APB_DW'(ref_q.minute);
			end
			REG_SECOND: begin
				prdata = APB_DW'(ref_q.second);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; it only loads when a command is taken, so a stalled beat holds.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q.out_year   <= time_nxt.year;
			out_data_q.out_month  <= time_nxt.month;
			out_data_q.out_day    <= time_nxt.day;
			out_data_q.out_hour   <= time_nxt.hour;
			out_data_q.out_minute <= time_nxt.minute;
			out_data_q.out_second <= time_nxt.second;
			out_data_q.relation   <= relation_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> design/csc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the calendar second counter, bound to the top level.
// Depends on csc_pkg and on calendar_second_counter.
module csc_checker import csc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	logic load_ok;

	// A load whose fields are already in range, with a day that exists in every month.
	assign load_ok = in_valid && in_ready && in_data.cmd == CMD_LOAD &&
		in_data.load_year <= YEAR_MAX && in_data.load_month >= 4'd1 &&
		in_data.load_month <= MONTH_MAX && in_data.load_day >= 5'd1 &&
		in_data.load_day <= 5'd28 && in_data.load_hour <= HOUR_MAX &&
		in_data.load_minute <= MINSEC_MAX && in_data.load_second <= MINSEC_MAX;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted command gave no result");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result stage");

	a_time_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.out_year <= YEAR_MAX && out_data.out_month >= 4'd1 &&
		out_data.out_month <= MONTH_MAX && out_data.out_day >= 5'd1 &&
		out_data.out_day <= month_length(out_data.out_month, out_data.out_year) &&
		out_data.out_hour <= HOUR_MAX && out_data.out_minute <= MINSEC_MAX &&
		out_data.out_second <= MINSEC_MAX)
		else $error("result time is not a valid date-time");

	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |=> out_data.out_year == $past(in_data.load_year) &&
		out_data.out_month == $past(in_data.load_month) &&
		out_data.out_day == $past(in_data.load_day) &&
		out_data.out_hour == $past(in_data.load_hour) &&
		out_data.out_minute == $past(in_data.load_minute) &&
		out_data.out_second == $past(in_data.load_second))
		else $error("in-range load not reflected in the result");

endmodule

bind calendar_second_counter csc_checker u_csc_checker (.*);
